### hdl/nfep_pkg.sv
`default_nettype none
package nfep_pkg;

  // Build-time defaults
  localparam int ADDR_BITS_DEF   = 32;
  localparam int QUEUE_DEPTH_DEF = 2;

  // Widths and divider length
  localparam int SS_W      = 25;
  localparam int DIV_STEPS = 32;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam int PADDR_W   = 5;

  // Erase unit sizes and alignment masks
  localparam logic [31:0] BLK64      = 32'h0001_0000;
  localparam logic [31:0] BLK32      = 32'h0000_8000;
  localparam logic [31:0] BLK4       = 32'h0000_1000;
  localparam logic [31:0] BLK64_MASK = 32'h0000_FFFF;
  localparam logic [31:0] BLK32_MASK = 32'h0000_7FFF;
  localparam logic [31:0] BLK4_MASK  = 32'h0000_0FFF;

  // Enable bits in erase_units
  localparam int UNIT_4K  = 0;
  localparam int UNIT_32K = 1;
  localparam int UNIT_64K = 2;

  // Command kinds
  localparam logic [2:0] KIND_CHIP  = 3'd0;
  localparam logic [2:0] KIND_B64   = 3'd1;
  localparam logic [2:0] KIND_B32   = 3'd2;
  localparam logic [2:0] KIND_S4    = 3'd3;
  localparam logic [2:0] KIND_NONE  = 3'd4;

  // Status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_MISALIGN = 3'd1;
  localparam logic [2:0] ST_BEYOND   = 3'd2;
  localparam logic [2:0] ST_NOTMULT  = 3'd3;
  localparam logic [2:0] ST_NOFIT    = 3'd4;
  localparam logic [2:0] ST_NOTHING  = 3'd5;

  // Register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_SECT_BYTES   = 3'd0;
  localparam logic [2:0] REG_CHIP_BYTES   = 3'd1;
  localparam logic [2:0] REG_ERASE_UNITS  = 3'd2;
  localparam logic [2:0] REG_WAIT_CHIP    = 3'd3;
  localparam logic [2:0] REG_WAIT_BLOCK64 = 3'd4;
  localparam logic [2:0] REG_WAIT_BLOCK32 = 3'd5;
  localparam logic [2:0] REG_WAIT_SECTOR4 = 3'd6;

  // Register reset values
  localparam logic [SS_W-1:0] SECT_BYTES_RST  = 25'd4096;
  localparam logic [31:0]     CHIP_BYTES_RST  = 32'd16777216;
  localparam logic [2:0]      ERASE_UNITS_RST = 3'd7;

  typedef struct packed {
    logic        op;
    logic [31:0] start_addr;
    logic [31:0] length;
  } req_t;

  typedef struct packed {
    logic [2:0]  cmd_kind;
    logic [31:0] cmd_addr;
    logic [31:0] wait_us;
    logic [2:0]  status;
    logic        last;
  } cmd_t;

  typedef struct packed {
    logic [SS_W-1:0] sect_bytes;
    logic [31:0]     chip_bytes;
    logic [2:0]      erase_units;
    logic [31:0]     wait_chip;
    logic [31:0]     wait_block64;
    logic [31:0]     wait_block32;
    logic [31:0]     wait_sector4;
  } cfg_t;

  // Request class decided by the front end
  typedef enum logic [2:0] {
    CLS_NEXT,
    CLS_MISALIGN,
    CLS_BEYOND,
    CLS_NOTMULT,
    CLS_EMPTY,
    CLS_GO
  } cls_t;

  typedef struct packed {
    cls_t        cls;
    logic [31:0] addr;
    logic [31:0] len;
  } job_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_t;

endpackage
`default_nettype wire

### hdl/nor_flash_erase_planner.sv
`default_nettype none
// Channel    | Dir | Handshake             | Payload
// -----------+-----+-----------------------+------------------------------------
// req        | in  | req_valid / req_stall | req_t: op, start_addr, length
// cmd        | out | cmd_valid / cmd_stall | cmd_t: cmd_kind, cmd_addr, wait_us,
//            |     |                       |        status, last
// config     | in  | APB psel/penable      | 7 registers at paddr = 4 * index
//
// A start request that passes the address checks is latched in the front end,
// run through the bit-serial remainder by the sector size, then queued once the
// queue has room. A next request or a start that fails a check is latched, then queued.
// The back end turns one queued request into one command per cycle when not stalled.
// Reset (rst, synchronous) restores the register defaults and drops any job.
// A stalled cmd output holds; the queue lets the front keep working meanwhile.
module nor_flash_erase_planner
  import nfep_pkg::*;
#(
  parameter int ADDR_BITS   = ADDR_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
  input  wire logic               clk,
  input  wire logic               rst,
  // request channel
  input  wire logic               req_valid,
  output logic                    req_stall,
  input  wire req_t               req,
  // command channel
  output logic                    cmd_valid,
  input  wire logic               cmd_stall,
  output cmd_t                    cmd,
  // register port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready
);

  cfg_t cfg;
  logic push;
  job_t push_item;
  logic q_full;
  logic pop;
  job_t pop_item;
  logic q_valid;

  // register file
  nfep_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // front end: accepts requests, checks alignment, end of chip and the
  // sector-multiple length, tags each request with its class
  nfep_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_full)
  );

  // short queue of classified requests
  nfep_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_valid   (q_valid)
  );

  // back end: holds the pending job and picks each erase command
  nfep_back #(
    .ADDR_BITS (ADDR_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (pop_item),
    .pop       (pop),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd)
  );

endmodule
`default_nettype wire

### hdl/nfep_cfg.sv
`default_nettype none
module nfep_cfg
  import nfep_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  output cfg_t                    cfg
);

  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = paddr[PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sect_bytes   <= SECT_BYTES_RST;
      cfg.chip_bytes   <= CHIP_BYTES_RST;
      cfg.erase_units  <= ERASE_UNITS_RST;
      cfg.wait_chip    <= '0;
      cfg.wait_block64 <= '0;
      cfg.wait_block32 <= '0;
      cfg.wait_sector4 <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_SECT_BYTES:   cfg.sect_bytes   <= pwdata[SS_W-1:0];
        REG_CHIP_BYTES:   cfg.chip_bytes   <= pwdata;
        REG_ERASE_UNITS:  cfg.erase_units  <= pwdata[2:0];
        REG_WAIT_CHIP:    cfg.wait_chip    <= pwdata;
        REG_WAIT_BLOCK64: cfg.wait_block64 <= pwdata;
        REG_WAIT_BLOCK32: cfg.wait_block32 <= pwdata;
        REG_WAIT_SECTOR4: cfg.wait_sector4 <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SECT_BYTES:   prdata = {{(32-SS_W){1'b0}}, cfg.sect_bytes};
      REG_CHIP_BYTES:   prdata = cfg.chip_bytes;
      REG_ERASE_UNITS:  prdata = {29'd0, cfg.erase_units};
      REG_WAIT_CHIP:    prdata = cfg.wait_chip;
      REG_WAIT_BLOCK64: prdata = cfg.wait_block64;
      REG_WAIT_BLOCK32: prdata = cfg.wait_block32;
      REG_WAIT_SECTOR4: prdata = cfg.wait_sector4;
      default:          prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

### hdl/nfep_front.sv
`default_nettype none
module nfep_front
  import nfep_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire cfg_t cfg,
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req,
  output logic      push,
  output job_t      push_item,
  input  wire logic q_full
);

  front_state_t state, state_next;

  req_t            item;
  cls_t            cls_pre;
  cls_t            cls_in;
  cls_t            cls_final;
  logic [SS_W-1:0] rem;
  logic [SS_W-1:0] rem_step;
  logic [31:0]     dvd;
  logic [CNT_W-1:0] cnt;

  logic            accept;
  logic [SS_W-1:0] ss_m1;
  logic            pow2;
  logic            misalign;
  logic [32:0]     end_sum;
  logic            beyond;
  logic [SS_W:0]   trial;
  logic            fits;

  assign accept = req_valid && !req_stall;

  // start checks that need no division
  always_comb begin
    ss_m1    = cfg.sect_bytes - SS_W'(1);
    pow2     = (cfg.sect_bytes != '0) && ((cfg.sect_bytes & ss_m1) == '0);
    misalign = pow2 && ((req.start_addr[SS_W-1:0] & ss_m1) != '0);
    end_sum  = {1'b0, req.start_addr} + {1'b0, req.length};
    beyond   = end_sum > {1'b0, cfg.chip_bytes};
    if (req.op) begin
      cls_in = CLS_NEXT;
    end else if (misalign) begin
      cls_in = CLS_MISALIGN;
    end else if (beyond) begin
      cls_in = CLS_BEYOND;
    end else if (cfg.sect_bytes == '0) begin
      cls_in = (req.length != '0) ? CLS_NOTMULT : CLS_EMPTY;
    end else begin
      cls_in = CLS_GO;  // remainder still to be found
    end
  end

  // restoring division step, one quotient bit per cycle
  always_comb begin
    trial = {rem, dvd[31]};
    fits  = trial >= {1'b0, cfg.sect_bytes};
    if (fits) begin
      rem_step = SS_W'(trial - {1'b0, cfg.sect_bytes});
    end else begin
      rem_step = trial[SS_W-1:0];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: begin
        if (accept) begin
          state_next = (cls_in == CLS_GO) ? F_DIV : F_PUSH;
        end
      end
      F_DIV: begin
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          state_next = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full) begin
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    req_stall = 1'b1;
    push      = 1'b0;
    cls_final = cls_pre;
    if (cls_pre == CLS_GO) begin
      if (rem != '0) begin
        cls_final = CLS_NOTMULT;
      end else if (item.length == '0) begin
        cls_final = CLS_EMPTY;
      end
    end
    case (state)
      F_IDLE:  req_stall = 1'b0;
      F_DIV:   req_stall = 1'b1;
      F_PUSH:  push      = !q_full;
      default: req_stall = 1'b1;
    endcase
    push_item.cls  = cls_final;
    push_item.addr = item.start_addr;
    push_item.len  = item.length;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item    <= req;
      cls_pre <= cls_in;
      rem     <= '0;
      dvd     <= req.length;
      cnt     <= '0;
    end else if (state == F_DIV) begin
      rem <= rem_step;
      dvd <= {dvd[30:0], 1'b0};
      cnt <= cnt + CNT_W'(1);
    end
  end

endmodule
`default_nettype wire

### hdl/nfep_queue.sv
`default_nettype none
module nfep_queue
  import nfep_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_item,
  output logic      full,
  input  wire logic pop,
  output job_t      pop_item,
  output logic      q_valid
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = count == CNT_W'(DEPTH);
  assign q_valid  = count != '0;
  assign pop_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

### hdl/nfep_back.sv
`default_nettype none
module nfep_back
  import nfep_pkg::*;
#(
  parameter int ADDR_BITS = ADDR_BITS_DEF
)
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire cfg_t cfg,
  input  wire logic q_valid,
  input  wire job_t q_item,
  output logic      pop,
  output logic      cmd_valid,
  input  wire logic cmd_stall,
  output cmd_t      cmd
);

  localparam logic [32:0] AddrSpan = 33'd1 << ADDR_BITS;
  localparam logic [31:0] AddrMask = 32'(AddrSpan - 33'd1);

  logic        job_active, job_active_next;
  logic [31:0] next_addr, next_addr_next;
  logic [31:0] remaining, remaining_next;

  logic        is_go;
  logic [31:0] cur_addr;
  logic [31:0] cur_rem;
  logic [31:0] step;
  logic [31:0] rem_after;
  logic [2:0]  kind;
  logic [31:0] wait_sel;
  logic        fit;
  cmd_t        res;

  assign pop = q_valid && (!cmd_valid || !cmd_stall);

  // greedy pick of the next erase command
  always_comb begin
    is_go    = q_item.cls == CLS_GO;
    cur_addr = is_go ? q_item.addr : next_addr;
    cur_rem  = is_go ? q_item.len  : remaining;
    fit      = 1'b1;
    kind     = KIND_NONE;
    wait_sel = '0;
    step     = '0;
    if (cur_rem == cfg.chip_bytes) begin
      kind     = KIND_CHIP;
      wait_sel = cfg.wait_chip;
      step     = cur_rem;
    end else if (cfg.erase_units[UNIT_64K] && cur_rem >= BLK64 &&
                 (cur_addr & BLK64_MASK) == '0) begin
      kind     = KIND_B64;
      wait_sel = cfg.wait_block64;
      step     = BLK64;
    end else if (cfg.erase_units[UNIT_32K] && cur_rem >= BLK32 &&
                 (cur_addr & BLK32_MASK) == '0) begin
      kind     = KIND_B32;
      wait_sel = cfg.wait_block32;
      step     = BLK32;
    end else if (cfg.erase_units[UNIT_4K] && cur_rem >= BLK4 &&
                 (cur_addr & BLK4_MASK) == '0) begin
      kind     = KIND_S4;
      wait_sel = cfg.wait_sector4;
      step     = BLK4;
    end else begin
      fit = 1'b0;
    end
    rem_after = cur_rem - step;
  end

  always_comb begin
    job_active_next = job_active;
    next_addr_next  = next_addr;
    remaining_next  = remaining;
    res.cmd_kind    = KIND_NONE;
    res.cmd_addr    = '0;
    res.wait_us     = '0;
    res.status      = ST_OK;
    res.last        = 1'b1;
    case (q_item.cls)
      CLS_NEXT, CLS_GO: begin
        if (q_item.cls == CLS_NEXT && !job_active) begin
          res.status = ST_NOTHING;
          res.last   = 1'b0;
        end else if (!fit) begin
          job_active_next = 1'b0;
          res.status      = ST_NOFIT;
        end else begin
          next_addr_next  = (kind == KIND_CHIP) ? cur_addr : cur_addr + step;
          remaining_next  = rem_after;
          job_active_next = rem_after != '0;
          res.cmd_kind    = kind;
          res.cmd_addr    = (kind == KIND_CHIP) ? '0 : (cur_addr & AddrMask);
          res.wait_us     = wait_sel;
          res.last        = rem_after == '0;
        end
      end
      CLS_MISALIGN: begin
        job_active_next = 1'b0;
        res.status      = ST_MISALIGN;
      end
      CLS_BEYOND: begin
        job_active_next = 1'b0;
        res.status      = ST_BEYOND;
      end
      CLS_NOTMULT: begin
        job_active_next = 1'b0;
        res.status      = ST_NOTMULT;
      end
      CLS_EMPTY: begin
        job_active_next = 1'b0;
      end
      default: begin
        job_active_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_active <= 1'b0;
      next_addr  <= '0;
      remaining  <= '0;
      cmd_valid  <= 1'b0;
    end else begin
      if (pop) begin
        job_active <= job_active_next;
        next_addr  <= next_addr_next;
        remaining  <= remaining_next;
        cmd_valid  <= 1'b1;
      end else if (!cmd_stall) begin
        cmd_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd <= res;
    end
  end

  a_last_ends_job: assert property (@(posedge clk) disable iff (rst)
    pop && res.last |=> !job_active)
    else $error("job still active after last command");

  a_active_has_rem: assert property (@(posedge clk) disable iff (rst)
    job_active |-> remaining != '0)
    else $error("active job with nothing remaining");

  a_idle_next_keeps: assert property (@(posedge clk) disable iff (rst)
    pop && res.status == ST_NOTHING |=> $stable(next_addr) && $stable(remaining))
    else $error("idle next request changed job state");

  a_no_pop_stalled: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_stall |-> !pop)
    else $error("result overwritten while stalled");

endmodule
`default_nettype wire

### tb/sv/nor_flash_erase_planner_tb.sv
`timescale 1ns / 1ps

import nfep_pkg::*;

// Request op codes
localparam logic OP_START = 1'b0;
localparam logic OP_NEXT  = 1'b1;

// Predicts the erase commands and holds them until the block returns them.
class erase_cmd_tracker;
  logic [SS_W-1:0] sect_bytes;
  logic [31:0]     chip_bytes;
  logic [2:0]      erase_units;
  logic [31:0]     wait_chip;
  logic [31:0]     wait_block64;
  logic [31:0]     wait_block32;
  logic [31:0]     wait_sector4;

  bit              job_active;
  logic [31:0]     next_addr;
  logic [31:0]     remaining;
  logic [31:0]     addr_mask;

  cmd_t            pending_cmds[$];
  int              fails;

  function new(logic [31:0] mask);
    addr_mask    = mask;
    sect_bytes   = SECT_BYTES_RST;
    chip_bytes   = CHIP_BYTES_RST;
    erase_units  = ERASE_UNITS_RST;
    wait_chip    = '0;
    wait_block64 = '0;
    wait_block32 = '0;
    wait_sector4 = '0;
    job_active   = 1'b0;
    next_addr    = '0;
    remaining    = '0;
    fails        = 0;
  endfunction

  function void set_reg(logic [2:0] idx, logic [31:0] value);
    case (idx)
      REG_SECT_BYTES:   sect_bytes   = value[SS_W-1:0];
      REG_CHIP_BYTES:   chip_bytes   = value;
      REG_ERASE_UNITS:  erase_units  = value[2:0];
      REG_WAIT_CHIP:    wait_chip    = value;
      REG_WAIT_BLOCK64: wait_block64 = value;
      REG_WAIT_BLOCK32: wait_block32 = value;
      REG_WAIT_SECTOR4: wait_sector4 = value;
      default: ;
    endcase
  endfunction

  // Greedy pick of the next erase command for the pending job.
  function cmd_t issue_step();
    cmd_t        c;
    logic [31:0] step;
    c    = '0;
    step = '0;
    if (remaining == chip_bytes) begin
      c.cmd_kind = KIND_CHIP;
      c.wait_us  = wait_chip;
      step       = remaining;
    end else if (erase_units[UNIT_64K] && remaining >= BLK64 &&
                 (next_addr & BLK64_MASK) == 0) begin
      c.cmd_kind = KIND_B64;
      c.cmd_addr = next_addr & addr_mask;
      c.wait_us  = wait_block64;
      step       = BLK64;
    end else if (erase_units[UNIT_32K] && remaining >= BLK32 &&
                 (next_addr & BLK32_MASK) == 0) begin
      c.cmd_kind = KIND_B32;
      c.cmd_addr = next_addr & addr_mask;
      c.wait_us  = wait_block32;
      step       = BLK32;
    end else if (erase_units[UNIT_4K] && remaining >= BLK4 &&
                 (next_addr & BLK4_MASK) == 0) begin
      c.cmd_kind = KIND_S4;
      c.cmd_addr = next_addr & addr_mask;
      c.wait_us  = wait_sector4;
      step       = BLK4;
    end else begin
      job_active = 1'b0;
      c.cmd_kind = KIND_NONE;
      c.status   = ST_NOFIT;
      c.last     = 1'b1;
      return c;
    end
    if (c.cmd_kind != KIND_CHIP) next_addr = next_addr + step;
    remaining = remaining - step;
    if (remaining == 0) job_active = 1'b0;
    c.status = ST_OK;
    c.last   = (remaining == 0);
    return c;
  endfunction

  function cmd_t plan_command(req_t r);
    cmd_t        c;
    logic [31:0] ss;
    c          = '0;
    c.cmd_kind = KIND_NONE;
    c.last     = 1'b1;
    ss         = 32'(sect_bytes);
    if (r.op == OP_NEXT) begin
      if (!job_active) begin
        c.status = ST_NOTHING;
        c.last   = 1'b0;
        return c;
      end
      return issue_step();
    end
    job_active = 1'b0;
    if (ss != 0 && (ss & (ss - 1)) == 0 && (r.start_addr & (ss - 1)) != 0) begin
      c.status = ST_MISALIGN;
    end else if ({1'b0, r.start_addr} + {1'b0, r.length} > {1'b0, chip_bytes}) begin
      c.status = ST_BEYOND;
    end else if (ss == 0 ? (r.length != 0) : (r.length % ss != 0)) begin
      c.status = ST_NOTMULT;
    end else if (r.length == 0) begin
      c.status = ST_OK;
    end else begin
      next_addr  = r.start_addr;
      remaining  = r.length;
      job_active = 1'b1;
      c          = issue_step();
    end
    return c;
  endfunction

  function void log_request(req_t r);
    pending_cmds.push_back(plan_command(r));
  endfunction

  function int outstanding();
    return pending_cmds.size();
  endfunction

  function void check_command(cmd_t got);
    cmd_t want;
    if (pending_cmds.size() == 0) begin
      $error("unexpected command: cmd_kind %0d cmd_addr %h status %0d",
             got.cmd_kind, got.cmd_addr, got.status);
      fails++;
      return;
    end
    want = pending_cmds.pop_front();
    if (got.cmd_kind !== want.cmd_kind) begin
      $error("cmd_kind: expected %0d, got %0d", want.cmd_kind, got.cmd_kind);
      fails++;
    end
    if (got.cmd_addr !== want.cmd_addr) begin
      $error("cmd_addr: expected %h, got %h", want.cmd_addr, got.cmd_addr);
      fails++;
    end
    if (got.wait_us !== want.wait_us) begin
      $error("wait_us: expected %h, got %h", want.wait_us, got.wait_us);
      fails++;
    end
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      fails++;
    end
    if (got.last !== want.last) begin
      $error("last: expected %0d, got %0d", want.last, got.last);
      fails++;
    end
  endfunction
endclass

module nor_flash_erase_planner_tb;
  import nfep_pkg::*;

  localparam int ADDR_BITS    = ADDR_BITS_DEF;
  // A start request still runs its division in the front end; leave margin.
  localparam int DRAIN_CYCLES = 40;
  // Long receiver hold-off, enough to fill the block's queue and stall req.
  localparam int LONG_HOLD    = 400;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int RANDOM_ITEMS = 850;
  localparam int PHASES       = 9;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_stall;
  req_t               req       = '0;
  logic               cmd_valid;
  logic               cmd_stall = 1'b0;
  cmd_t               cmd;
  logic               psel      = 1'b0;
  logic               penable   = 1'b0;
  logic               pwrite    = 1'b0;
  logic [PADDR_W-1:0] paddr     = '0;
  logic [31:0]        pwdata    = '0;
  logic [31:0]        prdata;
  logic               pready;

  erase_cmd_tracker tracker;
  int               cycles    = 0;
  int               sent      = 0;
  bit               quiet     = 1'b0;  // both sides run without gaps
  bit               hold_long = 1'b0;  // asks the receiver for one long hold-off

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  nor_flash_erase_planner #(
    .ADDR_BITS(ADDR_BITS)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd      (cmd),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Run limit; a hang anywhere ends here.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("nor_flash_erase_planner_tb NOT OK");
      $finish;
    end
  end

  // Every accepted command goes against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && cmd_valid === 1'b1 && cmd_stall == 1'b0) tracker.check_command(cmd);
  end

  // Command sink: draws a random hold-off per command, none when quiet, plus the
  // one long hold when asked. The long hold is counted here, independent of the
  // sender, so the request side keeps pushing while commands back up.
  initial begin : cmd_sink
    int hold;
    forever begin
      @(negedge clk);
      hold = quiet ? 0 : $urandom_range(0, 6);
      if (hold_long) begin
        hold      = hold + LONG_HOLD;
        hold_long = 1'b0;
      end
      if (hold > 0) begin
        cmd_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      cmd_stall <= 1'b0;
      do @(posedge clk); while (cmd_valid !== 1'b1);
    end
  end

  // APB write: setup cycle, then access cycle; pready is waited on anyway.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tracker.set_reg(idx, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic program_regs(input logic [31:0] ss, input logic [31:0] total,
                              input logic [31:0] units, input logic [31:0] w_chip,
                              input logic [31:0] w64, input logic [31:0] w32,
                              input logic [31:0] w4);
    write_reg(REG_SECT_BYTES, ss);
    write_reg(REG_CHIP_BYTES, total);
    write_reg(REG_ERASE_UNITS, units);
    write_reg(REG_WAIT_CHIP, w_chip);
    write_reg(REG_WAIT_BLOCK64, w64);
    write_reg(REG_WAIT_BLOCK32, w32);
    write_reg(REG_WAIT_SECTOR4, w4);
  endtask

  // One request: random gap with junk on the idle bus, then hold valid and
  // payload until accepted. The prediction is logged at the accepting edge.
  task automatic send_request(input req_t r);
    int   gap;
    req_t junk;
    gap             = quiet ? 0 : $urandom_range(0, 6);
    junk.op         = 1'($urandom_range(0, 1));
    junk.start_addr = $urandom;
    junk.length     = $urandom;
    @(negedge clk);
    if (gap > 0) begin
      req_valid <= 1'b0;
      req       <= junk;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (req_stall);
    tracker.log_request(r);
    sent++;
  endtask

  // Sender pause: bus idle until every predicted command is back, then let
  // the front end settle before registers may change.
  task automatic wait_drain();
    @(negedge clk);
    req_valid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic req_t start_req(input logic [31:0] a, input logic [31:0] len);
    req_t r;
    r.op         = OP_START;
    r.start_addr = a;
    r.length     = len;
    return r;
  endfunction

  // Next request; the address and length fields are don't-care, so randomize.
  function automatic req_t next_req();
    req_t r;
    r.op         = OP_NEXT;
    r.start_addr = $urandom;
    r.length     = $urandom;
    return r;
  endfunction

  // Mostly valid start request for the current register settings: length a
  // small multiple of the sector, address aligned to a random erase unit and
  // inside the chip, now and then a whole-chip request.
  function automatic req_t plan_start();
    logic [31:0] ss;
    logic [31:0] total;
    logic [31:0] unit_len;
    logic [31:0] g;
    logic [31:0] len;
    logic [31:0] a;
    int          maxk;
    bit          pow2;
    ss    = 32'(tracker.sect_bytes);
    total = tracker.chip_bytes;
    pow2  = (ss != 0) && ((ss & (ss - 1)) == 0);
    if (ss == 0) begin
      len = ($urandom_range(0, 2) == 0) ? 32'd0 : BLK4;
    end else begin
      unit_len = (pow2 && ss < BLK4) ? BLK4 : ss;
      maxk     = (unit_len >= 32'h0004_0000) ? 1 : int'(32'h0004_0000 / unit_len);
      if (maxk > 16) maxk = 16;
      len = unit_len * $urandom_range(0, maxk);
    end
    case ($urandom_range(0, 3))
      0: g = BLK4;
      1: g = BLK32;
      2: g = BLK64;
      default: g = pow2 ? ss : 32'd1;
    endcase
    if (pow2 && g < ss) g = ss;
    if (len <= total) a = $urandom_range(0, total - len) & ~(g - 1);
    else a = $urandom & ~(g - 1);
    if ($urandom_range(0, 7) == 0 && ss != 0 && total % ss == 0) begin
      a   = '0;
      len = total;
    end
    return start_req(a, len);
  endfunction

  // Start a job and walk it with next requests. A small cap leaves the job
  // pending so the following start replaces it.
  task automatic run_job(input req_t first, input int cap);
    int n;
    n = 0;
    send_request(first);
    while (tracker.job_active && n < cap) begin
      send_request(next_req());
      n++;
    end
  endtask

  task automatic send_noise();
    req_t r;
    case ($urandom_range(0, 2))
      0: begin
        r.op         = 1'($urandom_range(0, 1));
        r.start_addr = $urandom;
        r.length     = $urandom;
      end
      1: r = next_req();
      default: begin
        r = plan_start();
        r.start_addr[$urandom_range(0, 15)] ^= 1'b1;
      end
    endcase
    send_request(r);
  endtask

  task automatic configure_phase(input int p);
    logic [31:0] w_chip;
    logic [31:0] w64;
    logic [31:0] w32;
    logic [31:0] w4;
    w_chip = $urandom;
    w64    = $urandom;
    w32    = $urandom;
    w4     = $urandom;
    case (p)
      0: program_regs(32'd4096, 32'h0100_0000, 32'd7, w_chip, w64, w32, w4);
      1: program_regs(32'd1, 32'h0004_0000, $urandom_range(0, 7), w_chip, w64, w32, w4);
      2: program_regs(32'h0100_0000, 32'h0200_0000, 32'd7, w_chip, w64, w32, w4);
      3: program_regs(32'd0, 32'hFFFF_FFFF, $urandom_range(0, 7), w_chip, w64, w32, w4);
      4: program_regs(32'd12288, 32'h0100_0000, 32'd7, w_chip, w64, w32, w4);
      5: program_regs(32'h0001_0000, 32'd0, 32'd4, w_chip, w64, w32, w4);
      6: program_regs(32'h0000_8000, 32'hFFFF_FFFF, 32'd3, '1, '1, '1, '1);
      7: program_regs(32'd4096, 32'h0020_0000, $urandom_range(0, 7), '0, '0, '0, '0);
      default: program_regs(32'd1 << $urandom_range(0, 24), $urandom,
                            $urandom_range(0, 7), w_chip, w64, w32, w4);
    endcase
  endtask

  initial begin : stimulus
    int   p;
    int   target;
    int   cap;
    bit   paused;
    req_t r;
    tracker = new(32'(((64'd1) << ADDR_BITS) - 64'd1));
    paused  = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part, first under the reset register values.
    r.op         = OP_NEXT;
    r.start_addr = '1;
    r.length     = '1;
    send_request(r);                                     // next with no job
    send_request(start_req(32'd0, 32'd0));               // empty request
    send_request(start_req(32'd1, 32'd4096));            // misaligned
    send_request(start_req(32'hFFFF_F000, 32'h2000));    // end check, no wrap
    send_request(start_req(32'hFFFF_F000, 32'hFFFF_FFFF));
    send_request(start_req(32'd0, 32'd100));             // not a sector multiple
    wait_drain();
    program_regs(32'd4096, 32'h0100_0000, 32'd7, $urandom, $urandom, $urandom, $urandom);
    run_job(start_req(32'd0, 32'h0100_0000), 4);         // whole chip
    run_job(start_req(32'h0001_0000, 32'h0001_1000), 4); // 64K then 4K
    send_request(next_req());                            // job already done
    run_job(start_req(32'h0000_8000, 32'h0001_8000), 4); // 32K then 64K
    send_request(start_req(32'h0000_1000, 32'h3000));
    send_request(start_req(32'h0002_0000, 32'h1000));    // replaces pending job
    run_job(start_req(32'h00FF_F000, 32'h1000), 2);      // ends right at chip end
    wait_drain();
    write_reg(REG_ERASE_UNITS, 32'd0);
    send_request(start_req(32'd0, 32'd4096));            // no unit enabled
    wait_drain();
    write_reg(REG_ERASE_UNITS, 32'd1);
    run_job(start_req(32'h0001_0000, 32'h2000), 4);      // 4K only
    wait_drain();
    write_reg(REG_SECT_BYTES, 32'd0);
    send_request(start_req(32'd0, 32'd0));
    send_request(start_req(32'd5, 32'd1));               // zero sector size
    wait_drain();
    write_reg(REG_SECT_BYTES, 32'd12288);
    write_reg(REG_ERASE_UNITS, 32'd7);
    send_request(start_req(32'h0000_1001, 32'd12288));   // no alignment check
    run_job(start_req(32'h0000_3000, 32'h3000), 4);
    wait_drain();

    // Random part, one register setting per phase.
    for (p = 0; p < PHASES; p++) begin
      configure_phase(p);
      if (p == 0) hold_long = 1'b1;
      target = sent + RANDOM_ITEMS / PHASES;
      while (sent < target) begin
        if ($urandom_range(0, 29) == 0) quiet = !quiet;
        if (p == 4 && !paused && sent > target - 50) begin
          wait_drain();
          paused = 1'b1;
        end
        if ($urandom_range(0, 3) != 0) begin
          cap = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : 40;
          run_job(plan_start(), cap);
          if ($urandom_range(0, 5) == 0) send_request(next_req());
        end else begin
          send_noise();
        end
      end
      wait_drain();
    end

    if (tracker.fails == 0 && tracker.outstanding() == 0) begin
      $display("nor_flash_erase_planner_tb OK");
    end else begin
      $display("nor_flash_erase_planner_tb NOT OK");
    end
    $finish;
  end

endmodule
